/* rtl/rag_edge_merge_score_defines.svh */
// Assertion macros for the edge merge scorer.
`ifndef RAG_EDGE_MERGE_SCORE_DEFINES_SVH
`define RAG_EDGE_MERGE_SCORE_DEFINES_SVH

// same-cycle implication
`define RAG_EMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RAG_EMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rag_ems_pkg.sv */
// Types, constants and arithmetic helpers of the edge merge scorer.
`default_nettype none
package rag_ems_pkg;

  localparam int unsigned REGION_ID_BITS = 24;
  localparam int unsigned AREA_BITS      = 32;
  localparam int unsigned EDGE_W         = 24;
  localparam int unsigned SIZE_W         = 40;
  localparam int unsigned TAU_W          = 16;
  localparam int unsigned BS_W           = 24;
  localparam int unsigned MEAN_W         = 18;
  localparam int unsigned SCORE_W        = 64;
  localparam int unsigned MAG_W          = AREA_BITS + TAU_W;
  localparam int unsigned LINK_W         = MAG_W + 1;
  localparam int unsigned MDIV_STEPS     = MAG_W;
  localparam int unsigned BDIV_STEPS     = BS_W;
  localparam int unsigned SIZE_HALF      = SIZE_W / 2;
  localparam int unsigned BPROD_W        = BS_W + SIZE_W;
  localparam int unsigned PH_W           = BS_W + AREA_BITS - 8;
  localparam int unsigned PL_W           = BS_W + 8;
  localparam int unsigned CFG_AW         = 6;
  localparam int unsigned CFG_DW         = 64;
  localparam int unsigned TAU_RESET      = 32768;
  localparam int          Q16_ONE        = 65536;

  typedef enum logic [1:0] {
    STRAT_RAW  = 2'd0,
    STRAT_OPEN = 2'd1,
    STRAT_FRAC = 2'd2
  } strategy_e;

  typedef enum logic [2:0] {
    REG_STRATEGY  = 3'd0,
    REG_TAU       = 3'd1,
    REG_LINKAGE   = 3'd2,
    REG_BIAS_MODE = 3'd3,
    REG_RESPECT   = 3'd4,
    REG_SIZE_THR  = 3'd5,
    REG_BIAS_STR  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [EDGE_W-1:0]         edge_idx;
    logic                      self_loop;
    logic [REGION_ID_BITS-1:0] low;
    logic [REGION_ID_BITS-1:0] high;
    logic [AREA_BITS-1:0]      sel_contact;
    logic [AREA_BITS-1:0]      raw_contact;
    logic                      bias_on;
    logic [AREA_BITS-1:0]      bias_area;
  } info_t;

  typedef struct packed {
    info_t                info;
    logic                 sel_zero;
    logic                 raw_zero;
    logic [MAG_W-1:0]     sel_prod;
    logic [AREA_BITS-1:0] sel_bsum;
    logic [MAG_W-1:0]     raw_prod;
    logic [AREA_BITS-1:0] raw_bsum;
    logic [SIZE_W-1:0]    diff;
  } sta_t;

  typedef struct packed {
    info_t                       info;
    logic                        sel_neg;
    logic                        raw_neg;
    logic [MAG_W-1:0]            sel_mag;
    logic [MAG_W-1:0]            raw_mag;
    logic [BS_W+SIZE_HALF-1:0]   p_lo;
    logic [BS_W+SIZE_W-SIZE_HALF-1:0] p_hi;
  } stb_t;

  typedef struct packed {
    logic [AREA_BITS-1:0] rem;
    logic [MAG_W-1:0]     nq;
  } mdiv_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rem;
    logic [BS_W-1:0]   nq;
  } bdiv_t;

  typedef struct packed {
    info_t            info;
    logic             sel_neg;
    logic             raw_neg;
    logic [MAG_W-1:0] sel_mag;
    mdiv_t            sel_d;
    mdiv_t            raw_d;
    bdiv_t            bias_d;
  } divp_t;

  typedef struct packed {
    info_t                    info;
    logic signed [LINK_W-1:0] sel_mean;
    logic signed [LINK_W-1:0] raw_mean;
    logic signed [LINK_W-1:0] link;
    logic [BS_W-1:0]          bq;
    logic [PH_W-1:0]          ph;
    logic [PL_W-1:0]          pl;
  } ste_t;

  function automatic mdiv_t mdiv_step(mdiv_t s, logic [AREA_BITS-1:0] d);
    mdiv_t            r;
    logic [AREA_BITS:0] sh;
    sh   = {s.rem, s.nq[MAG_W-1]};
    r.nq = {s.nq[MAG_W-2:0], 1'b0};
    if (sh >= {1'b0, d}) begin
      sh      = sh - {1'b0, d};
      r.nq[0] = 1'b1;
    end
    r.rem = sh[AREA_BITS-1:0];
    return r;
  endfunction

  function automatic bdiv_t bdiv_step(bdiv_t s, logic [SIZE_W-1:0] d);
    bdiv_t           r;
    logic [SIZE_W:0] sh;
    sh   = {s.rem, s.nq[BS_W-1]};
    r.nq = {s.nq[BS_W-2:0], 1'b0};
    if (sh >= {1'b0, d}) begin
      sh      = sh - {1'b0, d};
      r.nq[0] = 1'b1;
    end
    r.rem = sh[SIZE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [LINK_W-1:0] to_link(logic neg, logic [MAG_W-1:0] mag);
    logic signed [LINK_W-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  function automatic logic [MEAN_W-1:0] sat_mean(logic signed [LINK_W-1:0] m);
    logic signed [LINK_W-1:0] one;
    logic [MEAN_W-1:0]        r;
    one = LINK_W'(Q16_ONE);
    if (m > one) begin
      r = MEAN_W'(Q16_ONE);
    end else if (m < -one) begin
      r = MEAN_W'(-Q16_ONE);
    end else begin
      r = m[MEAN_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/rag_edge_merge_score.sv */
// Pipeline from input transaction to result: 3 front stages, 48 divider stages of one
// quotient bit each, 1 back stage and the output register.
// Throughput: one edge per cycle unless the output stalls; the 48-bit restoring divider
// pipeline sets latency. The whole pipeline stalls together only while the output
// register is full and not taken. Reset clears all valid bits and the configuration
// registers (tau to 32768, others to 0); data registers are not reset.
`default_nettype none
`include "rag_edge_merge_score_defines.svh"
module rag_edge_merge_score (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      psel,
  input  wire logic                                      penable,
  input  wire logic                                      pwrite,
  input  wire logic [rag_ems_pkg::CFG_AW-1:0]            paddr,
  input  wire logic [rag_ems_pkg::CFG_DW-1:0]            pwdata,
  output logic      [rag_ems_pkg::CFG_DW-1:0]            prdata,
  output logic                                           pready,
  input  wire logic                                      in_valid_i,
  output logic                                           in_ready_o,
  input  wire logic [rag_ems_pkg::EDGE_W-1:0]            edge_index_i,
  input  wire logic [rag_ems_pkg::REGION_ID_BITS-1:0]    first_region_i,
  input  wire logic [rag_ems_pkg::REGION_ID_BITS-1:0]    second_region_i,
  input  wire logic [rag_ems_pkg::AREA_BITS-1:0]         total_area_i,
  input  wire logic [rag_ems_pkg::AREA_BITS-1:0]         total_bsum_i,
  input  wire logic [rag_ems_pkg::AREA_BITS-1:0]         open_area_i,
  input  wire logic [rag_ems_pkg::AREA_BITS-1:0]         open_bsum_i,
  input  wire logic [rag_ems_pkg::SIZE_W-1:0]            first_size_i,
  input  wire logic [rag_ems_pkg::SIZE_W-1:0]            second_size_i,
  output logic                                           out_valid_o,
  input  wire logic                                      out_ready_i,
  output logic      [rag_ems_pkg::EDGE_W-1:0]            edge_out_o,
  output logic                                           self_loop_o,
  output logic      [rag_ems_pkg::REGION_ID_BITS-1:0]    low_region_o,
  output logic      [rag_ems_pkg::REGION_ID_BITS-1:0]    high_region_o,
  output logic      [rag_ems_pkg::AREA_BITS-1:0]         selected_area_o,
  output logic signed [rag_ems_pkg::MEAN_W-1:0]          selected_mean_o,
  output logic      [rag_ems_pkg::AREA_BITS-1:0]         raw_area_o,
  output logic signed [rag_ems_pkg::MEAN_W-1:0]          raw_mean_o,
  output logic signed [rag_ems_pkg::SCORE_W-1:0]         merge_score_o,
  output logic                                           enqueue_o
);

  localparam int unsigned AW    = rag_ems_pkg::AREA_BITS;
  localparam int unsigned NS    = rag_ems_pkg::MDIV_STEPS;
  localparam int unsigned MW    = rag_ems_pkg::MAG_W;
  localparam int unsigned HW    = rag_ems_pkg::SIZE_HALF;
  localparam int unsigned PLO_W = rag_ems_pkg::BS_W + rag_ems_pkg::SIZE_HALF;
  localparam int unsigned PHI_W = rag_ems_pkg::BS_W + rag_ems_pkg::SIZE_W -
                                  rag_ems_pkg::SIZE_HALF;

  // configuration
  logic [1:0]                          strategy_q;
  logic [rag_ems_pkg::TAU_W-1:0]       tau_q;
  logic                                linkage_q;
  logic [1:0]                          bias_mode_q;
  logic                                respect_q;
  logic [rag_ems_pkg::SIZE_W-1:0]      size_thr_q;
  logic [rag_ems_pkg::BS_W-1:0]        bias_str_q;
  logic                                cfg_wr;
  logic [2:0]                          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q  <= '0;
      tau_q       <= rag_ems_pkg::TAU_W'(rag_ems_pkg::TAU_RESET);
      linkage_q   <= 1'b0;
      bias_mode_q <= '0;
      respect_q   <= 1'b0;
      size_thr_q  <= '0;
      bias_str_q  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rag_ems_pkg::REG_STRATEGY:  strategy_q  <= pwdata[1:0];
        rag_ems_pkg::REG_TAU:       tau_q       <= pwdata[rag_ems_pkg::TAU_W-1:0];
        rag_ems_pkg::REG_LINKAGE:   linkage_q   <= pwdata[0];
        rag_ems_pkg::REG_BIAS_MODE: bias_mode_q <= pwdata[1:0];
        rag_ems_pkg::REG_RESPECT:   respect_q   <= pwdata[0];
        rag_ems_pkg::REG_SIZE_THR:  size_thr_q  <= pwdata[rag_ems_pkg::SIZE_W-1:0];
        rag_ems_pkg::REG_BIAS_STR:  bias_str_q  <= pwdata[rag_ems_pkg::BS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rag_ems_pkg::REG_STRATEGY:  prdata = rag_ems_pkg::CFG_DW'(strategy_q);
      rag_ems_pkg::REG_TAU:       prdata = rag_ems_pkg::CFG_DW'(tau_q);
      rag_ems_pkg::REG_LINKAGE:   prdata = rag_ems_pkg::CFG_DW'(linkage_q);
      rag_ems_pkg::REG_BIAS_MODE: prdata = rag_ems_pkg::CFG_DW'(bias_mode_q);
      rag_ems_pkg::REG_RESPECT:   prdata = rag_ems_pkg::CFG_DW'(respect_q);
      rag_ems_pkg::REG_SIZE_THR:  prdata = rag_ems_pkg::CFG_DW'(size_thr_q);
      rag_ems_pkg::REG_BIAS_STR:  prdata = rag_ems_pkg::CFG_DW'(bias_str_q);
      default:                    prdata = '0;
    endcase
  end

  // pipeline control
  logic en;
  logic out_valid_q;
  logic va_q, vb_q, vc_q, ve_q;
  logic [NS-1:0] dv_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      dv_q        <= '0;
      ve_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q        <= in_valid_i;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      dv_q        <= {dv_q[NS-2:0], vc_q};
      ve_q        <= dv_q[NS-1];
      out_valid_q <= ve_q;
    end
  end

  // stage A: ordering, strategy selection, area * tau
  rag_ems_pkg::sta_t sta_d, sta_q;
  logic                             open_sel;
  logic [AW-1:0]                    sel_area, sel_bsum, bias_area;
  logic [rag_ems_pkg::SIZE_W-1:0]   minsize;

  always_comb begin
    open_sel  = (strategy_q == rag_ems_pkg::STRAT_OPEN) ||
                (strategy_q == rag_ems_pkg::STRAT_FRAC);
    sel_area  = open_sel ? open_area_i : total_area_i;
    sel_bsum  = open_sel ? open_bsum_i : total_bsum_i;
    bias_area = (respect_q && open_sel) ? open_area_i : total_area_i;
    minsize   = (first_size_i < second_size_i) ? first_size_i : second_size_i;

    sta_d.info.edge_idx  = edge_index_i;
    sta_d.info.self_loop = (first_region_i == second_region_i);
    sta_d.info.low       = (first_region_i < second_region_i) ? first_region_i
                                                              : second_region_i;
    sta_d.info.high      = (first_region_i < second_region_i) ? second_region_i
                                                              : first_region_i;
    sta_d.sel_zero       = (sel_area == '0);
    sta_d.raw_zero       = (total_area_i == '0);
    if (sta_d.sel_zero) begin
      sta_d.info.sel_contact = '0;
    end else begin
      sta_d.info.sel_contact = (strategy_q == rag_ems_pkg::STRAT_OPEN) ? open_area_i
                                                                       : total_area_i;
    end
    sta_d.info.raw_contact = total_area_i;
    sta_d.info.bias_area   = bias_area;
    sta_d.info.bias_on     = bias_mode_q[0] && (bias_area != '0) && (size_thr_q != '0) &&
                             (minsize < size_thr_q);
    sta_d.sel_prod         = MW'(sel_area) * MW'(tau_q);
    sta_d.sel_bsum         = sel_bsum;
    sta_d.raw_prod         = MW'(total_area_i) * MW'(tau_q);
    sta_d.raw_bsum         = total_bsum_i;
    sta_d.diff             = size_thr_q - minsize;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sta_q <= sta_d;
    end
  end

  // stage B: signed sums, bias numerator partial products
  rag_ems_pkg::stb_t stb_d, stb_q;
  logic [rag_ems_pkg::MAG_W-1:0] sel_b, raw_b;

  always_comb begin
    sel_b         = {sta_q.sel_bsum, rag_ems_pkg::TAU_W'(0)};
    raw_b         = {sta_q.raw_bsum, rag_ems_pkg::TAU_W'(0)};
    stb_d.info    = sta_q.info;
    stb_d.sel_neg = !sta_q.sel_zero && (sel_b > sta_q.sel_prod);
    stb_d.raw_neg = !sta_q.raw_zero && (raw_b > sta_q.raw_prod);
    if (sta_q.sel_zero) begin
      stb_d.sel_mag = '0;
    end else begin
      stb_d.sel_mag = stb_d.sel_neg ? sel_b - sta_q.sel_prod : sta_q.sel_prod - sel_b;
    end
    if (sta_q.raw_zero) begin
      stb_d.raw_mag = '0;
    end else begin
      stb_d.raw_mag = stb_d.raw_neg ? raw_b - sta_q.raw_prod : sta_q.raw_prod - raw_b;
    end
    stb_d.p_lo = PLO_W'(bias_str_q) * PLO_W'(sta_q.diff[HW-1:0]);
    stb_d.p_hi = PHI_W'(bias_str_q) * PHI_W'(sta_q.diff[rag_ems_pkg::SIZE_W-1:HW]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stb_q <= stb_d;
    end
  end

  // stage C: bias numerator, divider setup
  rag_ems_pkg::divp_t stc_d, stc_q;
  logic [rag_ems_pkg::BPROD_W-1:0] bprod;

  always_comb begin
    bprod = (rag_ems_pkg::BPROD_W'(stb_q.p_hi) << rag_ems_pkg::SIZE_HALF) +
            rag_ems_pkg::BPROD_W'(stb_q.p_lo);
    stc_d.info       = stb_q.info;
    stc_d.sel_neg    = stb_q.sel_neg;
    stc_d.raw_neg    = stb_q.raw_neg;
    stc_d.sel_mag    = stb_q.sel_mag;
    stc_d.sel_d.rem  = '0;
    stc_d.sel_d.nq   = stb_q.sel_mag;
    stc_d.raw_d.rem  = '0;
    stc_d.raw_d.nq   = stb_q.raw_mag;
    stc_d.bias_d.rem = bprod[rag_ems_pkg::BPROD_W-1 -: rag_ems_pkg::SIZE_W];
    stc_d.bias_d.nq  = bprod[rag_ems_pkg::BS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stc_q <= stc_d;
    end
  end

  // divider stages, one quotient bit each
  rag_ems_pkg::divp_t div_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_div
    rag_ems_pkg::divp_t din, dout;
    if (k == 0) begin : g_first
      assign din = stc_q;
    end else begin : g_next
      assign din = div_q[k-1];
    end
    always_comb begin
      dout       = din;
      dout.sel_d = rag_ems_pkg::mdiv_step(din.sel_d, din.info.sel_contact);
      dout.raw_d = rag_ems_pkg::mdiv_step(din.raw_d, din.info.raw_contact);
      if (k < rag_ems_pkg::BDIV_STEPS) begin
        dout.bias_d = rag_ems_pkg::bdiv_step(din.bias_d, size_thr_q);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[k] <= dout;
      end
    end
  end

  // stage E: signed means, linkage, bias scaling products
  rag_ems_pkg::ste_t ste_d, ste_q;
  rag_ems_pkg::divp_t dl;
  logic [rag_ems_pkg::MAG_W-1:0] sel_quo, raw_quo;

  always_comb begin
    dl             = div_q[NS-1];
    sel_quo        = (dl.info.sel_contact == '0) ? '0 : dl.sel_d.nq;
    raw_quo        = (dl.info.raw_contact == '0) ? '0 : dl.raw_d.nq;
    ste_d.info     = dl.info;
    ste_d.sel_mean = rag_ems_pkg::to_link(dl.sel_neg, sel_quo);
    ste_d.raw_mean = rag_ems_pkg::to_link(dl.raw_neg, raw_quo);
    ste_d.link     = linkage_q ? rag_ems_pkg::to_link(dl.sel_neg, dl.sel_mag >> 8)
                               : ste_d.sel_mean;
    ste_d.bq       = dl.bias_d.nq;
    ste_d.ph       = rag_ems_pkg::PH_W'(dl.bias_d.nq) *
                     rag_ems_pkg::PH_W'(dl.info.bias_area[AW-1:8]);
    ste_d.pl       = rag_ems_pkg::PL_W'(dl.bias_d.nq) *
                     rag_ems_pkg::PL_W'(dl.info.bias_area[7:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ste_q <= ste_d;
    end
  end

  // stage F: score and output register
  logic [rag_ems_pkg::SCORE_W-1:0]        bias_val;
  logic signed [rag_ems_pkg::SCORE_W-1:0] score;

  always_comb begin
    if (!ste_q.info.bias_on) begin
      bias_val = '0;
    end else if (linkage_q) begin
      bias_val = rag_ems_pkg::SCORE_W'(ste_q.ph) + rag_ems_pkg::SCORE_W'(ste_q.pl >> 8);
    end else begin
      bias_val = rag_ems_pkg::SCORE_W'(ste_q.bq);
    end
    score = rag_ems_pkg::SCORE_W'(ste_q.link) + $signed(bias_val);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      edge_out_o    <= ste_q.info.edge_idx;
      self_loop_o   <= ste_q.info.self_loop;
      low_region_o  <= ste_q.info.low;
      high_region_o <= ste_q.info.high;
      if (ste_q.info.self_loop) begin
        selected_area_o <= '0;
        selected_mean_o <= '0;
        raw_area_o      <= '0;
        raw_mean_o      <= '0;
        merge_score_o   <= '0;
        enqueue_o       <= 1'b0;
      end else begin
        selected_area_o <= ste_q.info.sel_contact;
        selected_mean_o <= rag_ems_pkg::sat_mean(ste_q.sel_mean);
        raw_area_o      <= ste_q.info.raw_contact;
        raw_mean_o      <= rag_ems_pkg::sat_mean(ste_q.raw_mean);
        merge_score_o   <= score;
        enqueue_o       <= (score > 0);
      end
    end
  end

  `RAG_EMS_ASSERT_NOW(a_stall_only_on_backpressure, !in_ready_o, out_valid_o && !out_ready_i, "stall without output backpressure")
  `RAG_EMS_ASSERT_NOW(a_self_loop_zero, out_valid_o && self_loop_o, !enqueue_o && merge_score_o == 0, "self loop with nonzero score")
  `RAG_EMS_ASSERT_NOW(a_enqueue_positive, out_valid_o && enqueue_o, !merge_score_o[rag_ems_pkg::SCORE_W-1] && merge_score_o != 0, "enqueue without positive score")
  `RAG_EMS_ASSERT_NEXT(a_last_div_to_e, en && dv_q[NS-1], ve_q, "divider result lost")

endmodule
`default_nettype wire

/* bench/rag_edge_merge_score_checker.sv */
// Checker for the edge merge scorer: predicts every result and compares it.
module rag_edge_merge_score_checker (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [rag_ems_pkg::CFG_AW-1:0]           paddr,
  input  logic [rag_ems_pkg::CFG_DW-1:0]           pwdata,
  input  logic                                     pready,
  input  logic                                     in_valid_i,
  input  logic                                     in_ready_o,
  input  logic [rag_ems_pkg::EDGE_W-1:0]           edge_index_i,
  input  logic [rag_ems_pkg::REGION_ID_BITS-1:0]   first_region_i,
  input  logic [rag_ems_pkg::REGION_ID_BITS-1:0]   second_region_i,
  input  logic [rag_ems_pkg::AREA_BITS-1:0]        total_area_i,
  input  logic [rag_ems_pkg::AREA_BITS-1:0]        total_bsum_i,
  input  logic [rag_ems_pkg::AREA_BITS-1:0]        open_area_i,
  input  logic [rag_ems_pkg::AREA_BITS-1:0]        open_bsum_i,
  input  logic [rag_ems_pkg::SIZE_W-1:0]           first_size_i,
  input  logic [rag_ems_pkg::SIZE_W-1:0]           second_size_i,
  input  logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  input  logic [rag_ems_pkg::EDGE_W-1:0]           edge_out_o,
  input  logic                                     self_loop_o,
  input  logic [rag_ems_pkg::REGION_ID_BITS-1:0]   low_region_o,
  input  logic [rag_ems_pkg::REGION_ID_BITS-1:0]   high_region_o,
  input  logic [rag_ems_pkg::AREA_BITS-1:0]        selected_area_o,
  input  logic [rag_ems_pkg::MEAN_W-1:0]           selected_mean_o,
  input  logic [rag_ems_pkg::AREA_BITS-1:0]        raw_area_o,
  input  logic [rag_ems_pkg::MEAN_W-1:0]           raw_mean_o,
  input  logic [rag_ems_pkg::SCORE_W-1:0]          merge_score_o,
  input  logic                                     enqueue_o,
  output int                                       errors_o,
  output int                                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [rag_ems_pkg::EDGE_W-1:0]         edge_idx;
    logic                                   self_loop;
    logic [rag_ems_pkg::REGION_ID_BITS-1:0] low;
    logic [rag_ems_pkg::REGION_ID_BITS-1:0] high;
    logic [rag_ems_pkg::AREA_BITS-1:0]      sel_area;
    logic [rag_ems_pkg::MEAN_W-1:0]         sel_mean;
    logic [rag_ems_pkg::AREA_BITS-1:0]      raw_area;
    logic [rag_ems_pkg::MEAN_W-1:0]         raw_mean;
    logic [rag_ems_pkg::SCORE_W-1:0]        score;
    logic                                   enq;
  } edge_score_t;

  typedef struct {
    logic        neg;
    logic [63:0] mag;
    logic [63:0] contact;
  } evidence_t;

  logic [1:0]  strategy_q;
  logic [15:0] tau_q;
  logic        linkage_q;
  logic [1:0]  bias_mode_q;
  logic        respect_q;
  logic [39:0] size_thr_q;
  logic [23:0] bias_str_q;

  edge_score_t expected_scores[$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = expected_scores.size();

  function automatic evidence_t gather(logic [1:0] s, logic [63:0] ta, logic [63:0] tb,
                                       logic [63:0] oa, logic [63:0] ob);
    evidence_t   e;
    logic [63:0] a, b, area, bsum;
    e = '{1'b0, 64'd0, 64'd0};
    if (s == rag_ems_pkg::STRAT_OPEN || s == rag_ems_pkg::STRAT_FRAC) begin
      if (oa == 0) return e;
      area = oa;
      bsum = ob;
      e.contact = (s == rag_ems_pkg::STRAT_OPEN) ? oa : ta;
    end else begin
      if (ta == 0) return e;
      area = ta;
      bsum = tb;
      e.contact = ta;
    end
    a = area * {48'd0, tau_q};
    b = bsum << 16;
    e.neg = b > a;
    e.mag = e.neg ? b - a : a - b;
    return e;
  endfunction

  function automatic longint mean_value(evidence_t e);
    logic [63:0] q;
    if (e.contact == 0) return 0;
    q = e.mag / e.contact;
    return e.neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [rag_ems_pkg::MEAN_W-1:0] clamp_mean(longint m);
    if (m > rag_ems_pkg::Q16_ONE) m = rag_ems_pkg::Q16_ONE;
    if (m < -rag_ems_pkg::Q16_ONE) m = -rag_ems_pkg::Q16_ONE;
    return m[rag_ems_pkg::MEAN_W-1:0];
  endfunction

  function automatic edge_score_t score_edge();
    edge_score_t      r;
    evidence_t        sel, raw;
    logic [1:0]       s;
    logic [63:0]      ta, tb, oa, ob, bias, bias_area, minsize;
    longint           link;
    logic signed [64:0] sum;
    ta = {32'd0, total_area_i};
    tb = {32'd0, total_bsum_i};
    oa = {32'd0, open_area_i};
    ob = {32'd0, open_bsum_i};
    s  = (strategy_q == 2'd3) ? rag_ems_pkg::STRAT_RAW : strategy_q;
    r = '{edge_index_i, 1'b0, '0, '0, '0, '0, '0, '0, '0, 1'b0};
    if (first_region_i == second_region_i) begin
      r.self_loop = 1'b1;
      r.low  = first_region_i;
      r.high = first_region_i;
      return r;
    end
    r.low  = (first_region_i < second_region_i) ? first_region_i : second_region_i;
    r.high = (first_region_i < second_region_i) ? second_region_i : first_region_i;
    sel = gather(s, ta, tb, oa, ob);
    raw = gather(rag_ems_pkg::STRAT_RAW, ta, tb, oa, ob);
    r.sel_area = sel.contact[rag_ems_pkg::AREA_BITS-1:0];
    r.sel_mean = clamp_mean(mean_value(sel));
    r.raw_area = raw.contact[rag_ems_pkg::AREA_BITS-1:0];
    r.raw_mean = clamp_mean(mean_value(raw));
    if (linkage_q) link = sel.neg ? -longint'(sel.mag >> 8) : longint'(sel.mag >> 8);
    else link = mean_value(sel);
    if (!respect_q) bias_area = raw.contact;
    else bias_area = (s == rag_ems_pkg::STRAT_RAW) ? ta : oa;
    minsize = (first_size_i < second_size_i) ? {24'd0, first_size_i} : {24'd0, second_size_i};
    bias = 0;
    if (bias_mode_q[0] && bias_area != 0 && size_thr_q != 0 && minsize < {24'd0, size_thr_q})
    begin
      bias = ({40'd0, bias_str_q} * ({24'd0, size_thr_q} - minsize)) / {24'd0, size_thr_q};
      if (linkage_q)
        bias = bias * (bias_area >> 8) + ((bias * (bias_area & 64'd255)) >> 8);
      if (bias[63]) bias = 64'h7fff_ffff_ffff_ffff;
    end
    sum = 65'(signed'(link)) + $signed({1'b0, bias});
    if (sum > 65'sh0_7fff_ffff_ffff_ffff) sum = 65'sh0_7fff_ffff_ffff_ffff;
    r.score = sum[63:0];
    r.enq   = sum > 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edge_score_t w;
    if (!rst_ni) begin
      strategy_q  <= rag_ems_pkg::STRAT_RAW;
      tau_q       <= 16'(rag_ems_pkg::TAU_RESET);
      linkage_q   <= 1'b0;
      bias_mode_q <= '0;
      respect_q   <= 1'b0;
      size_thr_q  <= '0;
      bias_str_q  <= '0;
      errors      = 0;
      expected_scores.delete();
    end else begin
      if (in_valid_i && in_ready_o)
        expected_scores.insert(expected_scores.size(), score_edge());
      if (out_valid_o && out_ready_i) begin
        if (expected_scores.size() == 0) begin
          report_mismatch("unexpected transaction", 64'(edge_out_o), '0);
        end else begin
          w = expected_scores.pop_front();
          if (edge_out_o != w.edge_idx)
            report_mismatch("edge_out", 64'(edge_out_o), 64'(w.edge_idx));
          if (self_loop_o != w.self_loop)
            report_mismatch("self_loop", 64'(self_loop_o), 64'(w.self_loop));
          if (low_region_o != w.low)
            report_mismatch("low_region", 64'(low_region_o), 64'(w.low));
          if (high_region_o != w.high)
            report_mismatch("high_region", 64'(high_region_o), 64'(w.high));
          if (selected_area_o != w.sel_area)
            report_mismatch("selected_area", 64'(selected_area_o), 64'(w.sel_area));
          if (selected_mean_o != w.sel_mean)
            report_mismatch("selected_mean", 64'(selected_mean_o), 64'(w.sel_mean));
          if (raw_area_o != w.raw_area)
            report_mismatch("raw_area", 64'(raw_area_o), 64'(w.raw_area));
          if (raw_mean_o != w.raw_mean)
            report_mismatch("raw_mean", 64'(raw_mean_o), 64'(w.raw_mean));
          if (merge_score_o != w.score) report_mismatch("merge_score", merge_score_o, w.score);
          if (enqueue_o != w.enq) report_mismatch("enqueue", 64'(enqueue_o), 64'(w.enq));
        end
      end
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[rag_ems_pkg::CFG_AW-1:3])
          rag_ems_pkg::REG_STRATEGY:  strategy_q  <= pwdata[1:0];
          rag_ems_pkg::REG_TAU:       tau_q       <= pwdata[15:0];
          rag_ems_pkg::REG_LINKAGE:   linkage_q   <= pwdata[0];
          rag_ems_pkg::REG_BIAS_MODE: bias_mode_q <= pwdata[1:0];
          rag_ems_pkg::REG_RESPECT:   respect_q   <= pwdata[0];
          rag_ems_pkg::REG_SIZE_THR:  size_thr_q  <= pwdata[39:0];
          rag_ems_pkg::REG_BIAS_STR:  bias_str_q  <= pwdata[23:0];
          default: ;
        endcase
      end
    end
  end
endmodule

/* bench/rag_edge_merge_score_test.sv */
// Top of the edge merge scorer testbench: clock, reset, stimulus and verdict.
module rag_edge_merge_score_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni = 1'b0;
  logic                                   psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [rag_ems_pkg::CFG_AW-1:0]         paddr = '0;
  logic [rag_ems_pkg::CFG_DW-1:0]         pwdata = '0;
  logic [rag_ems_pkg::CFG_DW-1:0]         prdata;
  logic                                   pready;
  logic                                   in_valid_i = 1'b0;
  logic                                   in_ready_o;
  logic [rag_ems_pkg::EDGE_W-1:0]         edge_index_i = '0;
  logic [rag_ems_pkg::REGION_ID_BITS-1:0] first_region_i = '0, second_region_i = '0;
  logic [rag_ems_pkg::AREA_BITS-1:0]      total_area_i = '0, total_bsum_i = '0;
  logic [rag_ems_pkg::AREA_BITS-1:0]      open_area_i = '0, open_bsum_i = '0;
  logic [rag_ems_pkg::SIZE_W-1:0]         first_size_i = '0, second_size_i = '0;
  logic                                   out_valid_o;
  logic                                   out_ready_i = 1'b0;
  logic [rag_ems_pkg::EDGE_W-1:0]         edge_out_o;
  logic                                   self_loop_o;
  logic [rag_ems_pkg::REGION_ID_BITS-1:0] low_region_o, high_region_o;
  logic [rag_ems_pkg::AREA_BITS-1:0]      selected_area_o, raw_area_o;
  logic signed [rag_ems_pkg::MEAN_W-1:0]  selected_mean_o, raw_mean_o;
  logic signed [rag_ems_pkg::SCORE_W-1:0] merge_score_o;
  logic                                   enqueue_o;
  int                                     errors, pending, cycles;
  bit                                     quiet = 1'b0, hold_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rag_edge_merge_score dut (.*);
  rag_edge_merge_score_checker checker_i (
    .*, .selected_mean_o(selected_mean_o), .raw_mean_o(raw_mean_o),
    .merge_score_o(merge_score_o), .errors_o(errors), .pending_o(pending));

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rag_edge_merge_score_test: errors");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(rag_ems_pkg::reg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rag_ems_pkg::CFG_AW'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(logic [1:0] strat, logic [15:0] tau, logic link, logic [1:0] mode,
                           logic resp, logic [39:0] thr, logic [23:0] strength);
    settle();
    write_reg(rag_ems_pkg::REG_STRATEGY, 64'(strat));
    write_reg(rag_ems_pkg::REG_TAU, 64'(tau));
    write_reg(rag_ems_pkg::REG_LINKAGE, 64'(link));
    write_reg(rag_ems_pkg::REG_BIAS_MODE, 64'(mode));
    write_reg(rag_ems_pkg::REG_RESPECT, 64'(resp));
    write_reg(rag_ems_pkg::REG_SIZE_THR, 64'(thr));
    write_reg(rag_ems_pkg::REG_BIAS_STR, 64'(strength));
  endtask

  task automatic send_edge(logic [rag_ems_pkg::EDGE_W-1:0] idx, logic [23:0] r1,
                           logic [23:0] r2, logic [31:0] ta, logic [31:0] tb,
                           logic [31:0] oa, logic [31:0] ob, logic [39:0] s1,
                           logic [39:0] s2);
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    edge_index_i    <= idx;
    first_region_i  <= r1;
    second_region_i <= r2;
    total_area_i    <= ta;
    total_bsum_i    <= tb;
    open_area_i     <= oa;
    open_bsum_i     <= ob;
    first_size_i    <= s1;
    second_size_i   <= s2;
    do @(posedge clk_i); while (!in_ready_o);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand_bits(int w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    return w >= 64 ? v : v & ((64'd1 << w) - 1);
  endfunction

  task automatic directed_edges();
    send_edge(24'h000000, 24'h000005, 24'h000005, 32'h100, 32'h80, 32'h100, 32'h80,
              40'd10, 40'd20);
    send_edge(24'hffffff, 24'hffffff, 24'h000000, 32'hffffffff, 32'h0, 32'hffffffff,
              32'hffffffff, 40'hffffffffff, 40'h0);
    send_edge(24'h000001, 24'h000000, 24'hffffff, 32'h0, 32'hffffffff, 32'h0, 32'h0,
              40'd0, 40'd0);
    send_edge(24'h000002, 24'h000010, 24'h000003, 32'h0, 32'h0, 32'h400, 32'h100,
              40'd5, 40'd7);
    send_edge(24'h000003, 24'h000003, 24'h000010, 32'h400, 32'h100, 32'h0, 32'h55,
              40'd1, 40'd900);
    send_edge(24'h000004, 24'h000001, 24'h000002, 32'h1, 32'hffffffff, 32'h1,
              32'hffffffff, 40'd3, 40'd3);
    send_edge(24'h000005, 24'h000002, 24'h000001, 32'hffffffff, 32'h0, 32'h1, 32'h0,
              40'hffffffffff, 40'hffffffffff);
    send_edge(24'h000006, 24'h123456, 24'h654321, 32'h1000, 32'h800, 32'h800, 32'h0,
              40'd0, 40'd1000);
    send_edge(24'h000007, 24'h0000ff, 24'h00ff00, 32'h300, 32'h300, 32'h200, 32'h200,
              40'd50, 40'd60);
  endtask

  task automatic random_edges(int count);
    logic [31:0] ta, tb, oa, ob;
    logic [23:0] r1, r2;
    logic [39:0] s1, s2;
    int          kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      r1 = 24'(rand_bits($urandom_range(1, 24)));
      r2 = 24'(rand_bits($urandom_range(1, 24)));
      ta = 32'(rand_bits($urandom_range(1, 32)));
      oa = ($urandom_range(0, 1) == 0) ? ta : ta - ta / 32'($urandom_range(1, 8));
      tb = ($urandom_range(0, 3) == 0) ? 32'(rand_bits(32)) : ta / 32'($urandom_range(1, 4));
      ob = ($urandom_range(0, 3) == 0) ? 32'(rand_bits(32)) : oa / 32'($urandom_range(1, 4));
      s1 = 40'(rand_bits($urandom_range(1, 40)));
      s2 = 40'(rand_bits($urandom_range(1, 40)));
      case (kind)
        0: r2 = r1;
        1: ta = 0;
        2: oa = 0;
        3: begin
          r1 = 24'(rand_bits(24)); r2 = 24'(rand_bits(24));
          ta = 32'(rand_bits(32)); tb = 32'(rand_bits(32));
          oa = 32'(rand_bits(32)); ob = 32'(rand_bits(32));
          s1 = 40'(rand_bits(40)); s2 = 40'(rand_bits(40));
        end
        default: ;
      endcase
      send_edge(24'(rand_bits(24)), r1, r2, ta, tb, oa, ob, s1, s2);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    directed_edges();
    configure(rag_ems_pkg::STRAT_FRAC, 16'd40000, 1'b1, 2'd3, 1'b1, 40'd1000, 24'hffffff);
    directed_edges();
    configure(rag_ems_pkg::STRAT_OPEN, 16'd0, 1'b0, 2'd1, 1'b0, 40'hffffffffff, 24'hffffff);
    random_edges(130);
    configure(rag_ems_pkg::STRAT_RAW, 16'hffff, 1'b1, 2'd1, 1'b1, 40'h1000000, 24'h010000);
    hold_req = 1'b1;
    random_edges(130);
    configure(rag_ems_pkg::STRAT_FRAC, 16'd32768, 1'b0, 2'd2, 1'b1, 40'd1, 24'd0);
    random_edges(130);
    configure(2'd3, 16'd12345, 1'b1, 2'd3, 1'b0, 40'hffffffffff, 24'hffffff);
    random_edges(130);
    for (int p = 0; p < 4; p++) begin
      configure(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom_range(0, 1)),
                2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                40'(rand_bits($urandom_range(1, 40))), 24'($urandom));
      random_edges(130);
    end
    configure(rag_ems_pkg::STRAT_FRAC, 16'hffff, 1'b1, 2'd1, 1'b1, 40'hffffffffff, 24'hffffff);
    quiet = 1'b1;
    random_edges(150);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    settle();
    if (errors == 0) begin
      $display("rag_edge_merge_score_test: clean");
    end else begin
      $display("rag_edge_merge_score_test: errors");
    end
    $finish;
  end
endmodule
